// ===== sv/tracked_object_kinematics_filter_macros.svh =====
// Assertion macros used by the kinematics filter controller
`ifndef TRACKED_OBJECT_KINEMATICS_FILTER_MACROS_SVH
`define TRACKED_OBJECT_KINEMATICS_FILTER_MACROS_SVH

// same-cycle implication, checked while out of reset
`define TOKF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define TOKF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tokf_pkg.sv =====
// Types, constants and helpers shared by the kinematics filter modules
`timescale 1ns / 1ps

package tokf_pkg;

    localparam int AXES       = 3;
    localparam int KINDS      = 3;
    localparam int LANES      = AXES * KINDS;
    localparam int DATA_W     = 32;
    localparam int ROW_W      = LANES * DATA_W;
    localparam int WIN_W      = 6;
    localparam int RATE_W     = 8;
    localparam int CNT_W      = 9;
    localparam int PROD_W     = DATA_W + 1 + RATE_W + 1;
    localparam int SQ_W       = 2 * DATA_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_RATE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_WIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_WIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACC_WIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_DB     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ACC_DB     = 3'd6;

    localparam logic [RATE_W-1:0] FRAME_RATE_RST = 8'd24;
    localparam logic [RATE_W-1:0] MISS_LIMIT_RST = 8'd24;
    localparam logic [WIN_W-1:0]  POS_WIN_RST    = 6'd8;
    localparam logic [WIN_W-1:0]  VEL_WIN_RST    = 6'd20;
    localparam logic [WIN_W-1:0]  ACC_WIN_RST    = 6'd20;
    localparam logic [31:0]       VEL_DB_RST     = 32'd164;
    localparam logic [31:0]       ACC_DB_RST     = 32'd32768;
    localparam logic [CNT_W-1:0]  MISS_CNT_MAX   = 9'd511;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VEL,
        ST_ACC,
        ST_SUM,
        ST_DIV,
        ST_SQ,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic diff_v;
        logic diff_a;
        logic sum_run;
        logic div_init;
        logic div_run;
        logic sq_init;
        logic sq_run;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic sum_done;
        logic div_done;
        logic sq_done;
    } stat_t;

    typedef struct packed {
        logic                     detected;
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] pos_z;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] avg_pos_x;
        logic signed [DATA_W-1:0] avg_pos_y;
        logic signed [DATA_W-1:0] avg_pos_z;
        logic signed [DATA_W-1:0] avg_vel_x;
        logic signed [DATA_W-1:0] avg_vel_y;
        logic signed [DATA_W-1:0] avg_vel_z;
        logic signed [DATA_W-1:0] avg_acc_x;
        logic signed [DATA_W-1:0] avg_acc_y;
        logic signed [DATA_W-1:0] avg_acc_z;
        logic                     tracking;
    } out_t;

    function automatic logic signed [DATA_W-1:0] sat_prod(input logic signed [PROD_W-1:0] v);
        logic [PROD_W-DATA_W:0] top;
        top = v[PROD_W-1:DATA_W-1];
        if ((&top) || !(|top)) begin
            return v[DATA_W-1:0];
        end else if (v[PROD_W-1]) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

endpackage

// ===== sv/tokf_datapath.sv =====
// Datapath: config registers, frame history, window sums, dividers and deadband
`timescale 1ns / 1ps

module tokf_datapath
    import tokf_pkg::*;
#(
    parameter int HISTORY_DEPTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  in_t                   in_data,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    output out_t                  out_data
);

    localparam int PTR_W  = $clog2(HISTORY_DEPTH);
    localparam int SUM_W  = DATA_W + PTR_W;
    localparam int KCNT_W = WIN_W + 1;
    localparam int DCNT_W = $clog2(SUM_W + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(HISTORY_DEPTH - 1);

    logic [RATE_W-1:0] frame_rate_reg;
    logic [RATE_W-1:0] miss_limit_reg;
    logic [WIN_W-1:0]  win_reg [KINDS];
    logic [31:0]       db_v_reg;
    logic [31:0]       db_a_reg;

    logic [WIN_W-1:0]  win_eff [KINDS];
    logic [WIN_W-1:0]  max_win;

    logic [ROW_W-1:0]  mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] valid_reg;
    logic [ROW_W-1:0]  rd_data_reg;
    logic              rd_hit_reg;
    logic [ROW_W-1:0]  row_eff;
    logic [ROW_W-1:0]  new_row;
    logic [PTR_W-1:0]  ptr_reg;
    logic [PTR_W-1:0]  walk_reg;
    logic [PTR_W-1:0]  newest;
    logic [PTR_W-1:0]  rd_addr;
    logic              rd_en;
    logic              sum_issue;

    in_t               in_reg;
    logic signed [DATA_W-1:0] pos_in [AXES];
    logic signed [DATA_W-1:0] old_val [LANES];
    logic signed [DATA_W-1:0] vel_reg [AXES];
    logic signed [DATA_W-1:0] vel_c [AXES];
    logic signed [DATA_W-1:0] acc_c [AXES];
    logic signed [RATE_W:0]   fr_s;
    logic [CNT_W-1:0]  miss_cnt_reg;
    logic              tracked_reg;
    logic              clear_c;

    logic [KCNT_W-1:0] k_issue_reg;
    logic [KCNT_W-1:0] rd_k_reg;
    logic              rd_live_reg;
    logic signed [SUM_W-1:0] sum_reg [LANES];

    logic              neg_reg [LANES];
    logic [SUM_W-1:0]  quo_reg [LANES];
    logic [WIN_W-1:0]  rem_reg [LANES];
    logic [DCNT_W-1:0] dcnt_reg;
    logic [DATA_W-1:0] mean_c [LANES];

    logic [DATA_W-1:0] mean_reg [LANES];
    logic [2:0]        j_reg;
    logic [3:0]        sq_idx;
    logic [DATA_W-1:0] mag;
    logic [SQ_W-1:0]   sq_c;
    logic [SQ_W-1:0]   prod_reg;
    logic [SQ_W-1:0]   acc_v_reg;
    logic [SQ_W-1:0]   acc_a_reg;
    out_t              out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_rate_reg <= FRAME_RATE_RST;
            miss_limit_reg <= MISS_LIMIT_RST;
            win_reg[0]     <= POS_WIN_RST;
            win_reg[1]     <= VEL_WIN_RST;
            win_reg[2]     <= ACC_WIN_RST;
            db_v_reg       <= VEL_DB_RST;
            db_a_reg       <= ACC_DB_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx)
                CFG_FRAME_RATE: frame_rate_reg <= cfg_data[RATE_W-1:0];
                CFG_MISS_LIMIT: miss_limit_reg <= cfg_data[RATE_W-1:0];
                CFG_POS_WIN:    win_reg[0]     <= cfg_data[WIN_W-1:0];
                CFG_VEL_WIN:    win_reg[1]     <= cfg_data[WIN_W-1:0];
                CFG_ACC_WIN:    win_reg[2]     <= cfg_data[WIN_W-1:0];
                CFG_VEL_DB:     db_v_reg       <= cfg_data[31:0];
                CFG_ACC_DB:     db_a_reg       <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        max_win = '0;
        for (int g = 0; g < KINDS; g++) begin
            if (win_reg[g] == '0) begin
                win_eff[g] = WIN_W'(1);
            end else if (int'(win_reg[g]) > HISTORY_DEPTH) begin
                win_eff[g] = WIN_W'(HISTORY_DEPTH);
            end else begin
                win_eff[g] = win_reg[g];
            end
            if (win_eff[g] > max_win) begin
                max_win = win_eff[g];
            end
        end
    end

    assign newest    = (ptr_reg == '0) ? LAST : ptr_reg - PTR_W'(1);
    assign sum_issue = cmd.sum_run && (k_issue_reg <= {1'b0, max_win});
    assign rd_en     = cmd.capture || sum_issue;
    assign rd_addr   = cmd.capture ? newest : walk_reg;
    assign row_eff   = rd_hit_reg ? rd_data_reg : '0;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (cmd.diff_a) begin
            mem[ptr_reg] <= new_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end else begin
            if (rd_en) begin
                rd_hit_reg <= valid_reg[rd_addr];
            end
            if (cmd.diff_a) begin
                valid_reg[ptr_reg] <= 1'b1;
            end
        end
    end

    assign pos_in[0] = in_reg.pos_x;
    assign pos_in[1] = in_reg.pos_y;
    assign pos_in[2] = in_reg.pos_z;
    assign fr_s      = signed'({1'b0, frame_rate_reg});
    assign clear_c   = miss_cnt_reg >= {1'b0, miss_limit_reg};

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            old_val[i] = row_eff[i*DATA_W +: DATA_W];
        end
        for (int a = 0; a < AXES; a++) begin
            logic signed [DATA_W:0]   dv;
            logic signed [DATA_W:0]   da;
            logic signed [PROD_W-1:0] pv;
            logic signed [PROD_W-1:0] pa;
            dv = {pos_in[a][DATA_W-1], pos_in[a]} - {old_val[a][DATA_W-1], old_val[a]};
            pv = dv * fr_s;
            vel_c[a] = sat_prod(pv);
            da = {vel_reg[a][DATA_W-1], vel_reg[a]}
                 - {old_val[AXES+a][DATA_W-1], old_val[AXES+a]};
            pa = da * fr_s;
            acc_c[a] = sat_prod(pa);
        end
        if (in_reg.detected) begin
            for (int a = 0; a < AXES; a++) begin
                new_row[a*DATA_W +: DATA_W]            = pos_in[a];
                new_row[(AXES+a)*DATA_W +: DATA_W]     = vel_reg[a];
                new_row[(2*AXES+a)*DATA_W +: DATA_W]   = acc_c[a];
            end
        end else if (clear_c) begin
            new_row = '0;
        end else begin
            new_row = row_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg <= in_data;
        end
        if (cmd.diff_v) begin
            for (int a = 0; a < AXES; a++) begin
                vel_reg[a] <= vel_c[a];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg      <= '0;
            walk_reg     <= '0;
            miss_cnt_reg <= '0;
            tracked_reg  <= 1'b0;
            k_issue_reg  <= '0;
            rd_k_reg     <= '0;
            rd_live_reg  <= 1'b0;
        end else begin
            rd_live_reg <= sum_issue;
            rd_k_reg    <= k_issue_reg;
            if (cmd.diff_a) begin
                ptr_reg     <= (ptr_reg == LAST) ? '0 : ptr_reg + PTR_W'(1);
                walk_reg    <= ptr_reg;
                k_issue_reg <= KCNT_W'(1);
                if (in_reg.detected) begin
                    miss_cnt_reg <= '0;
                    tracked_reg  <= 1'b1;
                end else begin
                    if (miss_cnt_reg != MISS_CNT_MAX) begin
                        miss_cnt_reg <= miss_cnt_reg + CNT_W'(1);
                    end
                    if (clear_c) begin
                        tracked_reg <= 1'b0;
                    end
                end
            end else if (sum_issue) begin
                walk_reg    <= (walk_reg == '0) ? LAST : walk_reg - PTR_W'(1);
                k_issue_reg <= k_issue_reg + KCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.diff_a) begin
            for (int i = 0; i < LANES; i++) begin
                sum_reg[i] <= '0;
            end
        end else if (rd_live_reg) begin
            for (int i = 0; i < LANES; i++) begin
                if (rd_k_reg <= {1'b0, win_eff[i/AXES]}) begin
                    sum_reg[i] <= sum_reg[i] + SUM_W'(old_val[i]);
                end
            end
        end
    end

    assign stat.sum_done = (k_issue_reg > {1'b0, max_win}) && !rd_live_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcnt_reg <= '0;
        end else if (cmd.div_init) begin
            dcnt_reg <= '0;
        end else if (cmd.div_run && !stat.div_done) begin
            dcnt_reg <= dcnt_reg + DCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < LANES; i++) begin
            logic [WIN_W:0] t;
            logic           ge;
            t  = {rem_reg[i], quo_reg[i][SUM_W-1]};
            ge = t >= {1'b0, win_eff[i/AXES]};
            if (cmd.div_init) begin
                neg_reg[i] <= sum_reg[i][SUM_W-1];
                quo_reg[i] <= sum_reg[i][SUM_W-1] ? -sum_reg[i] : sum_reg[i];
                rem_reg[i] <= '0;
            end else if (cmd.div_run && !stat.div_done) begin
                rem_reg[i] <= ge ? WIN_W'(t - {1'b0, win_eff[i/AXES]}) : WIN_W'(t);
                quo_reg[i] <= {quo_reg[i][SUM_W-2:0], ge};
            end
        end
    end

    assign stat.div_done = dcnt_reg == DCNT_W'(SUM_W);

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            mean_c[i] = neg_reg[i] ? -quo_reg[i][DATA_W-1:0] : quo_reg[i][DATA_W-1:0];
        end
    end

    assign sq_idx = (j_reg < 3'd6) ? 4'(j_reg) + 4'(AXES) : 4'(AXES);
    assign mag    = mean_reg[sq_idx][DATA_W-1] ? -mean_reg[sq_idx] : mean_reg[sq_idx];
    assign sq_c   = SQ_W'(mag) * SQ_W'(mag);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            j_reg <= '0;
        end else if (cmd.sq_init) begin
            j_reg <= '0;
        end else if (cmd.sq_run && !stat.sq_done) begin
            j_reg <= j_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sq_init) begin
            for (int i = 0; i < LANES; i++) begin
                mean_reg[i] <= mean_c[i];
            end
            acc_v_reg <= '0;
            acc_a_reg <= '0;
        end else if (cmd.sq_run && !stat.sq_done) begin
            if (j_reg < 3'd6) begin
                prod_reg <= sq_c;
            end
            if (j_reg >= 3'd1 && j_reg <= 3'd3) begin
                acc_v_reg <= acc_v_reg + prod_reg;
            end else if (j_reg >= 3'd4) begin
                acc_a_reg <= acc_a_reg + prod_reg;
            end
        end
    end

    assign stat.sq_done = j_reg == 3'd7;

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            logic v_zero;
            logic a_zero;
            v_zero = acc_v_reg < {16'b0, db_v_reg, 16'b0};
            a_zero = acc_a_reg < {16'b0, db_a_reg, 16'b0};
            out_reg.avg_pos_x <= mean_reg[0];
            out_reg.avg_pos_y <= mean_reg[1];
            out_reg.avg_pos_z <= mean_reg[2];
            out_reg.avg_vel_x <= v_zero ? '0 : mean_reg[3];
            out_reg.avg_vel_y <= v_zero ? '0 : mean_reg[4];
            out_reg.avg_vel_z <= v_zero ? '0 : mean_reg[5];
            out_reg.avg_acc_x <= a_zero ? '0 : mean_reg[6];
            out_reg.avg_acc_y <= a_zero ? '0 : mean_reg[7];
            out_reg.avg_acc_z <= a_zero ? '0 : mean_reg[8];
            out_reg.tracking  <= tracked_reg;
        end
    end

    assign out_data = out_reg;

endmodule

// ===== sv/tokf_ctrl.sv =====
// Controller state machine sequencing one frame through the datapath
`timescale 1ns / 1ps
`include "tracked_object_kinematics_filter_macros.svh"

module tokf_ctrl
    import tokf_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    output logic  m_valid,
    input  logic  m_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_VEL;
                end
            end
            ST_VEL: begin
                cmd.diff_v = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.diff_a = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum_run = 1'b1;
                if (stat.sum_done) begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_run = 1'b1;
                if (stat.div_done) begin
                    cmd.sq_init = 1'b1;
                    state_next  = ST_SQ;
                end
            end
            ST_SQ: begin
                cmd.sq_run = 1'b1;
                if (stat.sq_done) begin
                    cmd.finish = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `TOKF_ASSERT_NEXT(a_accept_starts, s_valid && s_ready, state_reg == ST_VEL, "accept did not start")
    `TOKF_ASSERT_NOW(a_one_side, s_ready, !m_valid, "input and result side open together")
    `TOKF_ASSERT_NEXT(a_finish_shows, cmd.finish, m_valid, "finished request not shown")
    `TOKF_ASSERT_NEXT(a_taken_idle, m_valid && m_ready, s_ready, "taken result did not free input")

endmodule

// ===== sv/tracked_object_kinematics_filter.sv =====
// Throughput: one frame at a time; next frame is taken the cycle after the result is taken.
// The window walk reads one history row per cycle; nine restoring dividers take one bit a cycle.
// Reset: synchronous active low; history reads as zero until written, config registers return to defaults.
`timescale 1ns / 1ps

module tracked_object_kinematics_filter
    import tokf_pkg::*;
#(
    parameter int HISTORY_DEPTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    tokf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tokf_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .in_data   (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (m_data)
    );

endmodule
